@@ sv/rc_ppm_pwm_pulse_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// RC pulse decoder assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RC_PPM_PWM_PULSE_DECODER_TOP_DEFINES_SVH
`define RC_PPM_PWM_PULSE_DECODER_TOP_DEFINES_SVH

// Condition holds at every edge out of reset.
`define RCPD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define RCPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RCPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rcpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpd_pkg
// Types, constants and helpers shared by the RC pulse decoder modules.
// ----------------------------------------------------------------------------
package rcpd_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int NUM_PORTS_DEF    = 8;

  // Widest channel / port index over the supported parameter range (up to 16)
  localparam int CH_MAX_W  = 4;
  // Wide enough to hold a count of 16 for range compares
  localparam int CNT_CMP_W = 5;

  localparam int TIME_W = 16;

  localparam logic [TIME_W-1:0] FRAME_GAP = 16'd2700;

  // Failsafe check looks at the first four channels
  localparam int               FS_CHANNELS  = 4;
  localparam int               FS_IDX_W     = 2;
  localparam logic [3:0]       FS_MASK_FULL = 4'hF;
  localparam logic [TIME_W-1:0] FS_STEP     = 16'd20;

  // Reset values of the configuration registers
  localparam logic              PPM_MODE_RST  = 1'b0;
  localparam logic [TIME_W-1:0] PULSE_MIN_RST = 16'd750;
  localparam logic [TIME_W-1:0] PULSE_MAX_RST = 16'd2250;
  localparam logic [TIME_W-1:0] FS_THRESH_RST = 16'd985;

  // Decoupling queue between front and back; power of two
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PPM_MODE  = 2'd0,
    REG_PULSE_MIN = 2'd1,
    REG_PULSE_MAX = 2'd2,
    REG_FS_THRESH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              ppm_mode;
    logic [TIME_W-1:0] width_lo;
    logic [TIME_W-1:0] width_hi;
    logic [TIME_W-1:0] failsafe_threshold;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic                stored_valid;
    logic [CH_MAX_W-1:0] channel;
    logic [TIME_W-1:0]   width;
    logic [TIME_W-1:0]   failsafe_count;
    logic [2:0]          read_index;
  } rec_t;

  // Result item as presented on the output channel
  typedef struct packed {
    logic              stored_valid;
    logic [2:0]        stored_channel;
    logic [TIME_W-1:0] stored_width;
    logic [TIME_W-1:0] failsafe_count_next;
    logic [TIME_W-1:0] read_value;
  } res_t;

  function automatic logic width_ok(input logic [TIME_W-1:0] w,
                                    input logic [TIME_W-1:0] lo,
                                    input logic [TIME_W-1:0] hi);
    return (w > lo) && (w < hi);
  endfunction

endpackage

@@ sv/rc_ppm_pwm_pulse_decoder_top.sv @@
// ----------------------------------------------------------------------------
// rc_ppm_pwm_pulse_decoder_top
// RC receiver input decoder for PPM streams or per-port PWM capture edges.
//
//   channel | direction | transfer on            | carries
//   in_     | in        | in_tvalid & in_tready  | edge event or width read
//   out_    | out       | out_tvalid & out_tready| stored width, failsafe, read
//   cfg_    | in        | cfg_we                 | mode, pulse limits, threshold
//
// One item per cycle sustained while out_tready holds; each item passes the
// queue register, then the output register, before its output transfer.
// The front updates frame/phase state in the accept cycle; the back applies
// the width store and failsafe mask in the cycle it pops the queue.
// A two-entry queue absorbs output stalls; in_tready drops when it is full.
// Reset is synchronous and clears the width store and all control state at
// once; no clearing pass. Rise stamps are written before they are read.
// ----------------------------------------------------------------------------
module rc_ppm_pwm_pulse_decoder_top
  import rcpd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int NUM_PORTS    = NUM_PORTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] in_port, [18:3] capture_time, [21:19] read_index,
  // [37:22] failsafe_count, [39:38] zero
  input  logic [39:0] in_tdata,
  // [0] cmd
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] stored_channel, [18:3] stored_width, [34:19] failsafe_count_next,
  // [50:35] read_value, [55:51] zero
  output logic [55:0] out_tdata,
  // [0] stored_valid
  output logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t cfg_r;
  rec_t front_rec;
  rec_t q_rec;
  res_t res;
  logic push;
  logic q_not_empty;
  logic q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ppm_mode           <= PPM_MODE_RST;
      cfg_r.width_lo           <= PULSE_MIN_RST;
      cfg_r.width_hi           <= PULSE_MAX_RST;
      cfg_r.failsafe_threshold <= FS_THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PPM_MODE:  cfg_r.ppm_mode           <= cfg_wdata[0];
        REG_PULSE_MIN: cfg_r.width_lo           <= cfg_wdata;
        REG_PULSE_MAX: cfg_r.width_hi           <= cfg_wdata;
        REG_FS_THRESH: cfg_r.failsafe_threshold <= cfg_wdata;
      endcase
    end
  end

  assign push = in_tvalid && in_tready;

  rcpd_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_PORTS    (NUM_PORTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .cmd            (cmd_t'(in_tuser[0])),
    .in_port        (in_tdata[2:0]),
    .capture_time   (in_tdata[18:3]),
    .read_index     (in_tdata[21:19]),
    .failsafe_count (in_tdata[37:22]),
    .cfg            (cfg_r),
    .rec            (front_rec)
  );

  rcpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (front_rec),
    .not_full  (in_tready),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_rec   (q_rec)
  );

  rcpd_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec_valid          (q_not_empty),
    .rec                (q_rec),
    .pop                (q_pop),
    .failsafe_threshold (cfg_r.failsafe_threshold),
    .res_valid          (out_tvalid),
    .res_ready          (out_tready),
    .res                (res)
  );

  assign out_tdata = {5'b00000, res.read_value, res.failsafe_count_next,
                      res.stored_width, res.stored_channel};
  assign out_tuser = res.stored_valid;

endmodule

@@ sv/rcpd_front.sv @@
// ----------------------------------------------------------------------------
// rcpd_front
// Edge classifier: tracks PPM frame position and per-port PWM phase, and
// turns each accepted item into a store/no-store record.
// ----------------------------------------------------------------------------
module rcpd_front
  import rcpd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int NUM_PORTS    = NUM_PORTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cmd_t              cmd,
  input  logic [2:0]        in_port,
  input  logic [TIME_W-1:0] capture_time,
  input  logic [2:0]        read_index,
  input  logic [TIME_W-1:0] failsafe_count,
  input  cfg_t              cfg,
  output rec_t              rec
);

  localparam int FC_W   = $clog2(NUM_CHANNELS + 1);
  localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic [TIME_W-1:0] last_edge_time_r, last_edge_time_nxt;
  logic [FC_W-1:0]   frame_channel_r, frame_channel_nxt;
  logic              port_phase_r   [NUM_PORTS];
  logic              port_phase_nxt [NUM_PORTS];
  logic [TIME_W-1:0] rise_time_r    [NUM_PORTS];
  logic [TIME_W-1:0] rise_time_nxt  [NUM_PORTS];

  logic [CH_MAX_W-1:0] port_ext;
  logic [PORT_W-1:0]   port_idx;
  logic                port_in_range;
  logic                port_has_ch;
  logic                fch_in_range;
  logic [TIME_W-1:0]   ppm_diff;
  logic [TIME_W-1:0]   pwm_w;

  assign port_ext      = CH_MAX_W'(in_port);
  assign port_idx      = PORT_W'(port_ext);
  assign port_in_range = CNT_CMP_W'(in_port) < CNT_CMP_W'(NUM_PORTS);
  assign port_has_ch   = CNT_CMP_W'(in_port) < CNT_CMP_W'(NUM_CHANNELS);
  assign fch_in_range  = frame_channel_r < FC_W'(NUM_CHANNELS);
  assign ppm_diff      = capture_time - last_edge_time_r;
  assign pwm_w         = capture_time - rise_time_r[port_idx];

  always_comb begin
    last_edge_time_nxt = last_edge_time_r;
    frame_channel_nxt  = frame_channel_r;
    port_phase_nxt     = port_phase_r;
    rise_time_nxt      = rise_time_r;
    rec                = '0;
    rec.read_index     = read_index;
    rec.failsafe_count = failsafe_count;
    if (push && cmd == CMD_EDGE) begin
      if (cfg.ppm_mode) begin
        last_edge_time_nxt = capture_time;
        if (ppm_diff > FRAME_GAP) begin
          // sync gap: restart the frame
          frame_channel_nxt = '0;
        end else begin
          if (fch_in_range && width_ok(ppm_diff, cfg.width_lo, cfg.width_hi)) begin
            rec.stored_valid = 1'b1;
            rec.channel      = CH_MAX_W'(frame_channel_r);
            rec.width        = ppm_diff;
          end
          if (fch_in_range) begin
            frame_channel_nxt = frame_channel_r + FC_W'(1);
          end
        end
      end else if (port_in_range) begin
        if (!port_phase_r[port_idx]) begin
          rise_time_nxt[port_idx]  = capture_time;
          port_phase_nxt[port_idx] = 1'b1;
        end else begin
          if (port_has_ch && width_ok(pwm_w, cfg.width_lo, cfg.width_hi)) begin
            rec.stored_valid = 1'b1;
            rec.channel      = port_ext;
            rec.width        = pwm_w;
          end
          port_phase_nxt[port_idx] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_time_r <= '0;
      frame_channel_r  <= '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        port_phase_r[i] <= 1'b0;
      end
    end else begin
      last_edge_time_r <= last_edge_time_nxt;
      frame_channel_r  <= frame_channel_nxt;
      port_phase_r     <= port_phase_nxt;
    end
  end

  // rise stamps are always written before a fall reads them
  always_ff @(posedge clk) begin
    rise_time_r <= rise_time_nxt;
  end

endmodule

@@ sv/rcpd_queue.sv @@
// ----------------------------------------------------------------------------
// rcpd_queue
// Small FIFO of classified records between the front and back stages.
// ----------------------------------------------------------------------------
`include "rc_ppm_pwm_pulse_decoder_top_defines.svh"

module rcpd_queue
  import rcpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output rec_t pop_rec
);

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign not_full  = cnt_r != CNT_W'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_rec   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  `RCPD_ASSERT_IMP(a_no_overflow, cnt_r == CNT_W'(DEPTH), !push, "push into full queue")
  `RCPD_ASSERT_IMP(a_no_underflow, cnt_r == '0, !pop, "pop from empty queue")
  `RCPD_ASSERT_NXT(a_cnt_track, push && !pop, cnt_r == $past(cnt_r) + CNT_W'(1),
                   "queue count lost a transfer")

endmodule

@@ sv/rcpd_back.sv @@
// ----------------------------------------------------------------------------
// rcpd_back
// Width store, failsafe good-mask, output register. Unless the output stalls,
// applies one record per cycle in order and presents it on the output channel.
// ----------------------------------------------------------------------------
`include "rc_ppm_pwm_pulse_decoder_top_defines.svh"

module rcpd_back
  import rcpd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rec_valid,
  input  rec_t              rec,
  output logic              pop,
  input  logic [TIME_W-1:0] failsafe_threshold,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  localparam int CH_W = $clog2(NUM_CHANNELS);

  logic [TIME_W-1:0] widths_r [NUM_CHANNELS];
  logic [3:0]        good_mask_r, good_mask_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r;

  logic [CH_MAX_W-1:0] ridx_ext;
  logic                ridx_in_range;
  logic                good_hit;
  logic [3:0]          mask_upd;
  logic                fs_fire;
  logic [TIME_W-1:0]   fc_nxt;
  logic [TIME_W-1:0]   read_val;
  res_t                res_nxt;

  assign pop = rec_valid && (!out_valid_r || res_ready);

  assign ridx_ext      = CH_MAX_W'(rec.read_index);
  assign ridx_in_range = CNT_CMP_W'(rec.read_index) < CNT_CMP_W'(NUM_CHANNELS);

  always_comb begin
    good_hit = rec.stored_valid &&
               (CNT_CMP_W'(rec.channel) < CNT_CMP_W'(FS_CHANNELS)) &&
               (rec.width > failsafe_threshold);
    mask_upd = good_mask_r | (good_hit ? (4'b0001 << rec.channel[FS_IDX_W-1:0]) : 4'b0000);
    fs_fire  = rec.stored_valid && (mask_upd == FS_MASK_FULL);

    fc_nxt = rec.failsafe_count;
    if (fs_fire) begin
      fc_nxt = ($signed(rec.failsafe_count) > $signed(FS_STEP)) ?
               rec.failsafe_count - FS_STEP : '0;
    end

    good_mask_nxt = good_mask_r;
    if (pop && rec.stored_valid) begin
      good_mask_nxt = fs_fire ? 4'b0000 : mask_upd;
    end

    // forward this item's own store to its read
    priority if (!ridx_in_range) begin
      read_val = '0;
    end else if (rec.stored_valid && rec.channel == ridx_ext) begin
      read_val = rec.width;
    end else begin
      read_val = widths_r[CH_W'(ridx_ext)];
    end

    res_nxt.stored_valid        = rec.stored_valid;
    res_nxt.stored_channel      = rec.channel[2:0];
    res_nxt.stored_width        = rec.width;
    res_nxt.failsafe_count_next = fc_nxt;
    res_nxt.read_value          = read_val;

    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_mask_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        widths_r[i] <= '0;
      end
    end else begin
      good_mask_r <= good_mask_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop && rec.stored_valid) begin
        widths_r[CH_W'(rec.channel)] <= rec.width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

  `RCPD_ASSERT_ALWAYS(a_mask_never_full, good_mask_r != FS_MASK_FULL,
                      "good mask left full after a store")
  `RCPD_ASSERT_NXT(a_pop_loads_out, pop, out_valid_r, "popped record not presented")
  `RCPD_ASSERT_IMP(a_idle_store_zero, out_valid_r && !res_r.stored_valid,
                   res_r.stored_channel == 3'd0 && res_r.stored_width == '0,
                   "store fields nonzero without a store")

endmodule
